// ----- rtl/efm_pkg.sv -----
// Shared constants, codes and widths for the motor controller failure monitor.
package efm_pkg;

    localparam int NUM_MOTORS = 12;
    localparam int SLOT_W     = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
    localparam int MASK_W     = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // item kinds
    localparam logic [1:0] KIND_REPORT = 2'd0;
    localparam logic [1:0] KIND_LAST   = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;

    // severity and margin codes
    localparam logic [1:0] SEV_INFO    = 2'd0;
    localparam logic [1:0] SEV_WARN    = 2'd1;
    localparam logic [1:0] SEV_CRIT    = 2'd2;
    localparam logic       MAR_LO      = 1'b0;
    localparam logic       MAR_HI      = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_AGE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CRIT_MASK   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WARN_MASK   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_DELAY  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FUNC  = 3'd5;

    // reset values of the configuration registers
    localparam logic [31:0] RST_TIMEOUT_US    = 32'd300000;
    localparam logic [31:0] RST_MARGIN_AGE_US = 32'd150000;
    localparam logic [15:0] RST_CRIT_MASK     = 16'd0;
    localparam logic [15:0] RST_WARN_MASK     = 16'd0;
    localparam logic [31:0] RST_RISE_DELAY_US = 32'd0;
    localparam logic [7:0]  RST_FIRST_FUNC    = 8'd101;

endpackage

// ----- rtl/efm_ifs.sv -----
// Channel interfaces: telemetry input, status result and configuration write.
interface efm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [63:0] time_now_us;
    logic [63:0] report_time_us;
    logic        current_positive;
    logic [15:0] failure_bits;
    logic        online;
    logic [7:0]  func_code;

    modport source (
        output valid, kind, time_now_us, report_time_us, current_positive,
               failure_bits, online, func_code,
        input  ready
    );
    modport sink (
        input  valid, kind, time_now_us, report_time_us, current_positive,
               failure_bits, online, func_code,
        output ready
    );
endinterface

interface efm_res_if;
    logic        valid;
    logic        ready;
    logic        healthy;
    logic [1:0]  severity;
    logic        margin;
    logic [3:0]  failed_count;
    logic [11:0] timed_out_mask;
    logic [11:0] fault_mask;

    modport source (
        output valid, healthy, severity, margin, failed_count, timed_out_mask, fault_mask,
        input  ready
    );
    modport sink (
        input  valid, healthy, severity, margin, failed_count, timed_out_mask, fault_mask,
        output ready
    );
endinterface

interface efm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [efm_pkg::CFG_IDX_W-1:0]  index;
    logic [efm_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/esc_failure_monitor.sv -----
// Motor controller failure monitor: per-report classification, batch aggregation, hysteresis.
//
//  channel    | dir | handshake     | payload
//  i_in_ch    | in  | valid/ready   | kind, times, current flag, failure word, online, function
//  o_res_ch   | out | valid/ready   | healthy, severity, margin, failed count, two masks
//  i_cfg_ch   | in  | valid/ready   | register index, write data (ready always high)
//
// From input beat to result: input register, then classify/aggregate/filter into the
// result register. One beat per cycle sustained unless a batch-end beat waits on the
// output; batch aggregates and hysteresis state update as a beat leaves the input register.
// Synchronous active-low reset clears aggregates, seen bits and hysteresis; config takes defaults.
// A batch-end beat waits in the input register while an untaken result blocks the output;
// other beats never wait on the output side.
module esc_failure_monitor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    efm_in_if.sink      i_in_ch,
    efm_res_if.source   o_res_ch,
    efm_cfg_if.sink     i_cfg_ch
);

    // configuration
    logic [31:0] r_cfg_timeout;
    logic [31:0] r_cfg_margin_age;
    logic [15:0] r_cfg_crit_mask;
    logic [15:0] r_cfg_warn_mask;
    logic [31:0] r_cfg_rise_delay;
    logic [7:0]  r_cfg_first_func;

    // input register
    logic        r_s1_valid;
    logic [1:0]  r_s1_kind;
    logic [63:0] r_s1_now;
    logic [63:0] r_s1_rtime;
    logic        r_s1_cur_pos;
    logic [15:0] r_s1_fails;
    logic        r_s1_online;
    logic [7:0]  r_s1_func;

    // state
    logic [efm_pkg::NUM_MOTORS-1:0] r_seen;
    logic        r_filt;
    logic        r_req;
    logic [63:0] r_change_time;
    logic [1:0]  r_worst_sev;
    logic        r_worst_mar;
    logic [3:0]  r_fail_cnt;
    logic [efm_pkg::MASK_W-1:0] r_tmo_bits;
    logic [efm_pkg::MASK_W-1:0] r_fault_bits;

    // result register
    logic        r_out_valid;
    logic        r_out_healthy;
    logic [1:0]  r_out_sev;
    logic        r_out_mar;
    logic [3:0]  r_out_cnt;
    logic [efm_pkg::MASK_W-1:0] r_out_tmo;
    logic [efm_pkg::MASK_W-1:0] r_out_fault;

    logic        out_free;
    logic        s1_is_end;
    logic        s1_is_report;
    logic        s1_adv;
    logic        fin;

    logic [7:0]  slot_raw;
    logic        slot_ok;
    logic [efm_pkg::SLOT_W-1:0] slot;
    logic        take;
    logic        heard;
    logic        seen_now;
    logic [63:0] age;
    logic        tmo;
    logic        mlow;
    logic        fail_any;
    logic        failed;
    logic [1:0]  rep_sev;
    logic        rep_mar;
    logic [efm_pkg::MASK_W-1:0]     slot_hot;
    logic [efm_pkg::NUM_MOTORS-1:0] seen_hot;

    logic [1:0]  ag_sev;
    logic        ag_mar;
    logic [3:0]  ag_cnt;
    logic [efm_pkg::MASK_W-1:0] ag_tmo;
    logic [efm_pkg::MASK_W-1:0] ag_fault;

    logic [1:0]  fin_sev;
    logic        fin_mar;
    logic        any_fail;
    logic        restart;
    logic        rise_met;
    logic        n_req;
    logic        n_filt;
    logic [63:0] n_change_time;
    logic [63:0] elapsed;

    // ---------------- handshakes ----------------
    assign out_free     = !r_out_valid || o_res_ch.ready;
    assign s1_is_end    = (r_s1_kind == efm_pkg::KIND_LAST) || (r_s1_kind == efm_pkg::KIND_EMPTY);
    assign s1_is_report = (r_s1_kind == efm_pkg::KIND_REPORT) || (r_s1_kind == efm_pkg::KIND_LAST);
    assign s1_adv       = r_s1_valid && (!s1_is_end || out_free);
    assign fin          = s1_adv && s1_is_end;
    assign i_in_ch.ready  = !r_s1_valid || s1_adv;
    assign i_cfg_ch.ready = 1'b1;

    // ---------------- report classification ----------------
    assign slot_raw = r_s1_func - r_cfg_first_func;
    assign slot_ok  = (r_s1_func >= r_cfg_first_func) && (slot_raw < 8'(efm_pkg::NUM_MOTORS));
    assign slot     = slot_raw[efm_pkg::SLOT_W-1:0];
    assign take     = s1_is_report && slot_ok;

    assign heard    = r_s1_cur_pos || (r_s1_rtime != 64'd0);
    assign seen_now = r_seen[slot] || heard;
    assign age      = r_s1_now - r_s1_rtime;
    assign tmo      = seen_now && (age > {32'd0, r_cfg_timeout});
    assign mlow     = seen_now && (age > {32'd0, r_cfg_margin_age});
    assign fail_any = (r_s1_fails != 16'd0);
    assign failed   = tmo || fail_any || !r_s1_online;

    always_comb begin
        rep_sev = efm_pkg::SEV_INFO;
        rep_mar = efm_pkg::MAR_HI;
        if (tmo) begin
            rep_sev = efm_pkg::SEV_CRIT;
            rep_mar = efm_pkg::MAR_LO;
        end else if (mlow) begin
            rep_mar = efm_pkg::MAR_LO;
        end
        if (fail_any) begin
            if ((r_s1_fails & r_cfg_crit_mask) != 16'd0) begin
                rep_sev = efm_pkg::SEV_CRIT;
                rep_mar = efm_pkg::MAR_LO;
            end else if ((r_s1_fails & r_cfg_warn_mask) != 16'd0) begin
                if (rep_sev < efm_pkg::SEV_WARN) rep_sev = efm_pkg::SEV_WARN;
                rep_mar = efm_pkg::MAR_LO;
            end
        end
        if (!r_s1_online) begin
            if (rep_sev < efm_pkg::SEV_WARN) rep_sev = efm_pkg::SEV_WARN;
            rep_mar = efm_pkg::MAR_LO;
        end
    end

    always_comb begin
        for (int i = 0; i < efm_pkg::MASK_W; i++) begin
            slot_hot[i] = take && (32'(slot) == 32'(i));
        end
        for (int j = 0; j < efm_pkg::NUM_MOTORS; j++) begin
            seen_hot[j] = take && heard && (32'(slot) == 32'(j));
        end
    end

    // ---------------- batch aggregates after this report ----------------
    assign ag_cnt   = (take && failed && (r_fail_cnt != 4'hF)) ? r_fail_cnt + 4'd1 : r_fail_cnt;
    assign ag_tmo   = tmo      ? (r_tmo_bits | slot_hot)   : r_tmo_bits;
    assign ag_fault = fail_any ? (r_fault_bits | slot_hot) : r_fault_bits;

    always_comb begin
        ag_sev = r_worst_sev;
        ag_mar = r_worst_mar;
        if (take) begin
            if (rep_sev > r_worst_sev) begin
                ag_sev = rep_sev;
                ag_mar = rep_mar;
            end else if ((rep_sev == r_worst_sev) && (rep_mar < r_worst_mar)) begin
                ag_mar = rep_mar;
            end
        end
    end

    // ---------------- batch end: escalation and hysteresis ----------------
    assign any_fail = (ag_cnt != 4'd0);

    always_comb begin
        fin_sev = ag_sev;
        fin_mar = ag_mar;
        if ((ag_cnt > 4'd1) && (ag_sev < efm_pkg::SEV_CRIT)) begin
            fin_sev = efm_pkg::SEV_CRIT;
            fin_mar = efm_pkg::MAR_LO;
        end
    end

    assign restart = (any_fail != r_filt) && (any_fail != r_req);

    always_comb begin
        n_req         = r_req;
        n_change_time = r_change_time;
        if (any_fail != r_filt) begin
            if (restart) begin
                n_req         = any_fail;
                n_change_time = r_s1_now;
            end
        end else begin
            n_req = r_filt;
        end
    end

    // a fresh change starts at zero elapsed, so only the stored time needs subtracting
    assign elapsed  = r_s1_now - r_change_time;
    assign rise_met = restart ? (r_cfg_rise_delay == 32'd0)
                              : (elapsed >= {32'd0, r_cfg_rise_delay});

    always_comb begin
        n_filt = r_filt;
        if (n_req != r_filt) begin
            if (r_filt) begin
                n_filt = 1'b0;      // falls at once
            end else if (rise_met) begin
                n_filt = 1'b1;
            end
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_timeout    <= efm_pkg::RST_TIMEOUT_US;
            r_cfg_margin_age <= efm_pkg::RST_MARGIN_AGE_US;
            r_cfg_crit_mask  <= efm_pkg::RST_CRIT_MASK;
            r_cfg_warn_mask  <= efm_pkg::RST_WARN_MASK;
            r_cfg_rise_delay <= efm_pkg::RST_RISE_DELAY_US;
            r_cfg_first_func <= efm_pkg::RST_FIRST_FUNC;
        end else if (i_cfg_ch.valid) begin
            case (i_cfg_ch.index)
                efm_pkg::CFG_TIMEOUT:    r_cfg_timeout    <= i_cfg_ch.data;
                efm_pkg::CFG_MARGIN_AGE: r_cfg_margin_age <= i_cfg_ch.data;
                efm_pkg::CFG_CRIT_MASK:  r_cfg_crit_mask  <= i_cfg_ch.data[15:0];
                efm_pkg::CFG_WARN_MASK:  r_cfg_warn_mask  <= i_cfg_ch.data[15:0];
                efm_pkg::CFG_RISE_DELAY: r_cfg_rise_delay <= i_cfg_ch.data;
                efm_pkg::CFG_FIRST_FUNC: r_cfg_first_func <= i_cfg_ch.data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in_ch.ready) begin
            r_s1_valid <= i_in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_ch.valid && i_in_ch.ready) begin
            r_s1_kind    <= i_in_ch.kind;
            r_s1_now     <= i_in_ch.time_now_us;
            r_s1_rtime   <= i_in_ch.report_time_us;
            r_s1_cur_pos <= i_in_ch.current_positive;
            r_s1_fails   <= i_in_ch.failure_bits;
            r_s1_online  <= i_in_ch.online;
            r_s1_func    <= i_in_ch.func_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen        <= '0;
            r_filt        <= 1'b0;
            r_req         <= 1'b0;
            r_change_time <= 64'd0;
            r_worst_sev   <= efm_pkg::SEV_INFO;
            r_worst_mar   <= efm_pkg::MAR_HI;
            r_fail_cnt    <= 4'd0;
            r_tmo_bits    <= '0;
            r_fault_bits  <= '0;
        end else if (s1_adv) begin
            r_seen <= r_seen | seen_hot;
            if (s1_is_end) begin
                r_filt        <= n_filt;
                r_req         <= n_req;
                r_change_time <= n_change_time;
                r_worst_sev   <= efm_pkg::SEV_INFO;
                r_worst_mar   <= efm_pkg::MAR_HI;
                r_fail_cnt    <= 4'd0;
                r_tmo_bits    <= '0;
                r_fault_bits  <= '0;
            end else begin
                r_worst_sev   <= ag_sev;
                r_worst_mar   <= ag_mar;
                r_fail_cnt    <= ag_cnt;
                r_tmo_bits    <= ag_tmo;
                r_fault_bits  <= ag_fault;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin) begin
            r_out_valid <= 1'b1;
        end else if (o_res_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_out_healthy <= !n_filt;
            r_out_sev     <= n_filt ? fin_sev : efm_pkg::SEV_INFO;
            r_out_mar     <= n_filt ? fin_mar : efm_pkg::MAR_HI;
            r_out_cnt     <= ag_cnt;
            r_out_tmo     <= ag_tmo;
            r_out_fault   <= ag_fault;
        end
    end

    assign o_res_ch.valid          = r_out_valid;
    assign o_res_ch.healthy        = r_out_healthy;
    assign o_res_ch.severity       = r_out_sev;
    assign o_res_ch.margin         = r_out_mar;
    assign o_res_ch.failed_count   = r_out_cnt;
    assign o_res_ch.timed_out_mask = r_out_tmo;
    assign o_res_ch.fault_mask     = r_out_fault;

    // ---------------- assertions ----------------
    // no failed report in the batch means the filter has dropped
    a_zero_fail_healthy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_cnt == 4'd0)) |-> r_out_healthy)
        else $error("result with no failures reported unhealthy");

    // a healthy result carries neutral severity and margin
    a_healthy_neutral: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_healthy) |->
        ((r_out_sev == efm_pkg::SEV_INFO) && (r_out_mar == efm_pkg::MAR_HI)))
        else $error("healthy result with non-neutral severity or margin");

    // aggregates start empty after every batch end
    a_batch_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin |=> ((r_fail_cnt == 4'd0) && (r_tmo_bits == '0) && (r_fault_bits == '0)
                 && (r_worst_sev == efm_pkg::SEV_INFO)))
        else $error("batch aggregates not cleared after batch end");

    // a beat held in the input register is not overwritten
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_kind) && $stable(r_s1_now)))
        else $error("stalled input beat lost");

    // the filter only reports failure once some report has failed
    a_filt_needs_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin && n_filt) |-> any_fail)
        else $error("filtered failure without any failed report");

endmodule
